// File: hw/rtl/gzhp_pkg.sv
// Package for the gzip header parser: beat payload types and header constants.
// No dependencies; imported by the parser top level and its checker.
package gzhp_pkg;

   localparam int HDR_LEN_BITS    = 20;
   localparam int DATA_START_BITS = 21;

   localparam logic [HDR_LEN_BITS-1:0]    HDR_LEN_MAX    = 20'hFFFFF;
   localparam logic [DATA_START_BITS-1:0] DATA_START_PAD = 21'd8;

   localparam logic [7:0]  GZIP_ID1       = 8'h1F;
   localparam logic [7:0]  METHOD_DEFLATE = 8'd8;
   localparam logic [15:0] FIXED_SKIP     = 16'd6;
   localparam logic [15:0] PART_SKIP      = 16'd2;
   localparam logic [15:0] MAGIC_SKIP     = 16'd1;
   localparam logic [15:0] PAD_MAGIC_SKIP = 16'd2;

   // Bit positions in the header flags byte.
   localparam int FLAG_PART    = 1;
   localparam int FLAG_EXTRA   = 2;
   localparam int FLAG_NAME    = 3;
   localparam int FLAG_COMMENT = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_start;
   } req_payload_type;

   typedef struct packed {
      logic                       status;
      logic [7:0]                 method;
      logic [HDR_LEN_BITS-1:0]    header_length;
      logic [DATA_START_BITS-1:0] data_start;
   } rsp_payload_type;

endpackage

// File: hw/rtl/gzip_header_parser_unit.sv
// Top level of the gzip header parser: byte-wide header state machine and
// a two-deep result buffer. Depends on gzhp_pkg.
//
// Usage:
//   The req channel carries one stream byte per beat; stream_start marks the
//   first byte of a new stream and restarts parsing on that byte. The rsp
//   channel carries one beat per header: status, method, header length and a
//   data start of header length plus eight, or zero for a rejected method.
//   Bytes after the header are consumed and dropped until the next stream_start.
//   Each byte is handled by the state machine as its beat is accepted; when the
//   beat that ends the header is accepted, its result is registered for rsp.
//   Throughput is one byte per cycle while req_ready is high. When the receiver
//   stalls, a finished result waits in the output register and parsing goes on; a
//   second result lands in a skid register, and only while that register is full
//   does req_ready drop.
//   Reset (synchronous) returns the parser to waiting for a stream start and
//   empties both result registers.
module gzip_header_parser_unit
   import gzhp_pkg::*;
#(
   parameter int OFFSET_BITS = 20
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   localparam logic [3:0] PH_IDLE    = 4'd0;
   localparam logic [3:0] PH_MAGIC   = 4'd1;
   localparam logic [3:0] PH_METHOD  = 4'd2;
   localparam logic [3:0] PH_FLAGS   = 4'd3;
   localparam logic [3:0] PH_FIXED   = 4'd4;
   localparam logic [3:0] PH_PART    = 4'd5;
   localparam logic [3:0] PH_XLEN_LO = 4'd6;
   localparam logic [3:0] PH_XLEN_HI = 4'd7;
   localparam logic [3:0] PH_EXTRA   = 4'd8;
   localparam logic [3:0] PH_NAME    = 4'd9;
   localparam logic [3:0] PH_COMMENT = 4'd10;
   localparam logic [3:0] PH_DONE    = 4'd11;

   localparam logic [1:0] SEC_PART    = 2'd0;
   localparam logic [1:0] SEC_EXTRA   = 2'd1;
   localparam logic [1:0] SEC_NAME    = 2'd2;
   localparam logic [1:0] SEC_COMMENT = 2'd3;

   logic [3:0]             phase_ff, phase_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in, offset_inc;
   logic [15:0]            skip_ff, skip_in, skip_dec;
   logic [7:0]             flags_ff, flags_in;
   logic [7:0]             method_ff, method_in;
   logic [7:0]             xlen_ff, xlen_in;
   logic [3:0]             phase_next;
   logic                   emit, failed;
   logic [32:0]            offset_wide;
   logic [HDR_LEN_BITS-1:0] hdr_len;
   rsp_payload_type        result;

   logic            out_valid_ff, skid_valid_ff;
   rsp_payload_type out_data_ff, skid_data_ff;
   logic            req_fire, rsp_fire, result_fire;

   // First enabled optional section at or after sec.
   function automatic logic [3:0] enter_section(input logic [1:0] sec, input logic [7:0] flags);
      logic [3:0] ph;
      ph = PH_DONE;
      if (sec <= SEC_COMMENT && flags[FLAG_COMMENT]) ph = PH_COMMENT;
      if (sec <= SEC_NAME && flags[FLAG_NAME])       ph = PH_NAME;
      if (sec <= SEC_EXTRA && flags[FLAG_EXTRA])     ph = PH_XLEN_LO;
      if (sec == SEC_PART && flags[FLAG_PART])       ph = PH_PART;
      return ph;
   endfunction

   assign offset_inc = (offset_ff == '1) ? offset_ff : offset_ff + 1'b1;
   assign skip_dec   = skip_ff - 16'd1;

   always_comb begin
      phase_next = phase_ff;
      offset_in  = offset_ff;
      skip_in    = skip_ff;
      flags_in   = flags_ff;
      method_in  = method_ff;
      xlen_in    = xlen_ff;
      failed     = 1'b0;
      if (req_data.stream_start) begin
         phase_next = PH_MAGIC;
         offset_in  = OFFSET_BITS'(1);
         skip_in    = (req_data.data_byte == GZIP_ID1) ? MAGIC_SKIP : PAD_MAGIC_SKIP;
         flags_in   = '0;
         method_in  = '0;
         xlen_in    = '0;
      end else begin
         case (phase_ff)
            PH_MAGIC: begin
               offset_in = offset_inc;
               skip_in   = skip_dec;
               if (skip_dec == '0) phase_next = PH_METHOD;
            end
            PH_METHOD: begin
               offset_in = offset_inc;
               method_in = req_data.data_byte;
               if (req_data.data_byte != METHOD_DEFLATE) begin
                  failed     = 1'b1;
                  phase_next = PH_DONE;
               end else begin
                  phase_next = PH_FLAGS;
               end
            end
            PH_FLAGS: begin
               offset_in  = offset_inc;
               flags_in   = req_data.data_byte;
               skip_in    = FIXED_SKIP;
               phase_next = PH_FIXED;
            end
            PH_FIXED: begin
               offset_in = offset_inc;
               skip_in   = skip_dec;
               if (skip_dec == '0) begin
                  phase_next = enter_section(SEC_PART, flags_ff);
                  if (phase_next == PH_PART) skip_in = PART_SKIP;
               end
            end
            PH_PART: begin
               offset_in = offset_inc;
               skip_in   = skip_dec;
               if (skip_dec == '0) phase_next = enter_section(SEC_EXTRA, flags_ff);
            end
            PH_XLEN_LO: begin
               offset_in  = offset_inc;
               xlen_in    = req_data.data_byte;
               phase_next = PH_XLEN_HI;
            end
            PH_XLEN_HI: begin
               offset_in = offset_inc;
               skip_in   = {req_data.data_byte, xlen_ff};
               if ({req_data.data_byte, xlen_ff} == 16'd0) begin
                  phase_next = enter_section(SEC_NAME, flags_ff);
               end else begin
                  phase_next = PH_EXTRA;
               end
            end
            PH_EXTRA: begin
               offset_in = offset_inc;
               skip_in   = skip_dec;
               if (skip_dec == '0) phase_next = enter_section(SEC_NAME, flags_ff);
            end
            PH_NAME: begin
               offset_in = offset_inc;
               if (req_data.data_byte == 8'd0) phase_next = enter_section(SEC_COMMENT, flags_ff);
            end
            PH_COMMENT: begin
               offset_in = offset_inc;
               if (req_data.data_byte == 8'd0) phase_next = PH_DONE;
            end
            default: begin
               phase_next = PH_IDLE;
            end
         endcase
      end
      emit     = (phase_next == PH_DONE);
      phase_in = emit ? PH_IDLE : phase_next;
   end

   // The reported length saturates at the width of the result field.
   always_comb begin
      offset_wide = 33'(offset_in);
      if (offset_wide > 33'(HDR_LEN_MAX)) begin
         hdr_len = HDR_LEN_MAX;
      end else begin
         hdr_len = offset_wide[HDR_LEN_BITS-1:0];
      end
      result.status        = failed;
      result.method        = method_in;
      result.header_length = hdr_len;
      result.data_start    = failed ? '0 : DATA_START_BITS'(hdr_len) + DATA_START_PAD;
   end

   assign req_ready   = !skid_valid_ff;
   assign req_fire    = req_valid && req_ready;
   assign rsp_fire    = out_valid_ff && rsp_ready;
   assign result_fire = req_fire && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         offset_ff <= '0;
         skip_ff   <= '0;
         flags_ff  <= '0;
         method_ff <= '0;
         xlen_ff   <= '0;
      end else if (req_fire) begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         skip_ff   <= skip_in;
         flags_ff  <= flags_in;
         method_ff <= method_in;
         xlen_ff   <= xlen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_fire) begin
         if (skid_valid_ff) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end else if (result_fire) begin
            out_data_ff <= result;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end else if (result_fire) begin
         if (out_valid_ff) begin
            skid_data_ff  <= result;
            skid_valid_ff <= 1'b1;
         end else begin
            out_data_ff  <= result;
            out_valid_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// File: hw/rtl/gzhp_checker.sv
// Port-level checker for the gzip header parser, bound to the top level.
// Depends on gzhp_pkg and gzip_header_parser_unit.
module gzhp_checker
   import gzhp_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input req_payload_type req_data,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // A result beat that is not taken stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // A rejected method never reports a data start.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> rsp_data.data_start == '0 &&
         rsp_data.method != METHOD_DEFLATE)
      else $error("rejected header carries a data start");

   // An accepted header is deflate and its data start is the length plus eight.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.status |-> rsp_data.method == METHOD_DEFLATE &&
         rsp_data.data_start == DATA_START_BITS'(rsp_data.header_length) + DATA_START_PAD)
      else $error("accepted header has inconsistent fields");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind gzip_header_parser_unit gzhp_checker u_gzhp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
